// ----- design/mcsg_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsg_pkg
// Shared widths, constants and command/status types of the midpoint circle
// span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsg_pkg;

    // request field widths
    localparam int CENTER_W   = 8;
    localparam int RADIUS_W   = 6;
    localparam int COLOR_W    = 16;

    // result coordinate width (wraps two's complement)
    localparam int COORD_W    = 10;

    // radius bits actually used from the request
    localparam int RADIUS_BITS = 6;

    // walk limits and internal widths
    localparam int MAX_RESULTS = 48;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int X_W         = RADIUS_BITS + 1;
    localparam int Y_W         = RADIUS_BITS + 2;
    localparam int DEC_W       = RADIUS_BITS + 6;
    localparam int CALC_W      = 16;

    // decision variable constants
    localparam int DEC_INIT      = 3;
    localparam int DEC_STEP_DIAG = 10;
    localparam int DEC_STEP_AXIS = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_MASK = RADIUS_W'((1 << RADIUS_BITS) - 1);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } mcsg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } mcsg_status_t;

endpackage

`default_nettype wire

// ----- design/mcsg_ifs.sv -----
// ----------------------------------------------------------------------------
// mcsg interfaces
// Valid/ready channels for circle requests and span results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcsg_req_if import mcsg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0] radius;
    logic [COLOR_W-1:0]  fill_color;

    modport source (output valid, output center_x, output center_y,
                    output radius, output fill_color, input ready);
    modport sink   (input valid, input center_x, input center_y,
                    input radius, input fill_color, output ready);
endinterface

interface mcsg_span_if import mcsg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] outer_left;
    logic signed [COORD_W-1:0] outer_right;
    logic signed [COORD_W-1:0] outer_row_below;
    logic signed [COORD_W-1:0] outer_row_above;
    logic signed [COORD_W-1:0] inner_left;
    logic signed [COORD_W-1:0] inner_right;
    logic signed [COORD_W-1:0] inner_row_below;
    logic signed [COORD_W-1:0] inner_row_above;
    logic [COLOR_W-1:0]        span_color;
    logic                      last_step;

    modport source (output valid, output outer_left, output outer_right,
                    output outer_row_below, output outer_row_above,
                    output inner_left, output inner_right,
                    output inner_row_below, output inner_row_above,
                    output span_color, output last_step, input ready);
    modport sink   (input valid, input outer_left, input outer_right,
                    input outer_row_below, input outer_row_above,
                    input inner_left, input inner_right,
                    input inner_row_below, input inner_row_above,
                    input span_color, input last_step, output ready);
endinterface

`default_nettype wire

// ----- design/midpoint_circle_span_generator.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_span_generator
// Walks the midpoint circle decision variable for one request and emits the
// four horizontal fill spans of every step.
//
// Usage:
//   req  : circle request beat (center_x, center_y, radius, fill_color),
//          taken when valid and ready are both high.
//   span : one beat per step with outer/inner span columns and rows, the
//          request colour, and last_step set on the final beat of a circle.
//   The first span beat is valid the cycle after the request is taken.
//   Further beats follow one per cycle while the receiver keeps ready high;
//   a circle of radius r gives about r/sqrt(2) + 2 beats, capped at 48.
//   req.ready is high only between circles: the next request is taken in the
//   cycle after the final beat. The step rate is set by the single shared
//   x/y/decision update. When the receiver stalls, the current beat holds
//   unchanged and the walk waits. Reset returns the controller to idle with
//   no beat pending.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_span_generator import mcsg_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    mcsg_req_if.sink  req,
    mcsg_span_if.source span
);

    mcsg_cmd_t    cmd;
    mcsg_status_t status;

    // controller
    mcsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .span_valid (span.valid),
        .span_ready (span.ready),
        .cmd        (cmd),
        .status     (status)
    );

    // datapath
    mcsg_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .center_x        (req.center_x),
        .center_y        (req.center_y),
        .radius          (req.radius),
        .fill_color      (req.fill_color),
        .outer_left      (span.outer_left),
        .outer_right     (span.outer_right),
        .outer_row_below (span.outer_row_below),
        .outer_row_above (span.outer_row_above),
        .inner_left      (span.inner_left),
        .inner_right     (span.inner_right),
        .inner_row_below (span.inner_row_below),
        .inner_row_above (span.inner_row_above),
        .span_color      (span.span_color)
    );

    assign span.last_step = status.last;

endmodule

`default_nettype wire

// ----- design/mcsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcsg_ctrl
// Controller: takes a request, then presents one span beat per step until
// the final step has been taken by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsg_ctrl import mcsg_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    output logic        span_valid,
    input  wire logic   span_ready,
    output mcsg_cmd_t   cmd,
    input  wire mcsg_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic span_take;

    // handshake decode
    assign req_ready  = (state_reg == ST_IDLE);
    assign span_valid = (state_reg == ST_EMIT);
    assign span_take  = span_valid && span_ready;

    assign cmd.load = req_valid && req_ready;
    assign cmd.step = span_take && !status.last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (span_take && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/mcsg_datapath.sv -----
// ----------------------------------------------------------------------------
// mcsg_datapath
// Holds the latched request, the x/y offsets and the midpoint decision
// variable; advances one step per command and forms the span coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsg_datapath import mcsg_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mcsg_cmd_t            cmd,
    output mcsg_status_t              status,
    input  wire logic [CENTER_W-1:0]  center_x,
    input  wire logic [CENTER_W-1:0]  center_y,
    input  wire logic [RADIUS_W-1:0]  radius,
    input  wire logic [COLOR_W-1:0]   fill_color,
    output logic signed [COORD_W-1:0] outer_left,
    output logic signed [COORD_W-1:0] outer_right,
    output logic signed [COORD_W-1:0] outer_row_below,
    output logic signed [COORD_W-1:0] outer_row_above,
    output logic signed [COORD_W-1:0] inner_left,
    output logic signed [COORD_W-1:0] inner_right,
    output logic signed [COORD_W-1:0] inner_row_below,
    output logic signed [COORD_W-1:0] inner_row_above,
    output logic [COLOR_W-1:0]        span_color
);

    logic [X_W-1:0]          x_reg,     x_next;
    logic signed [Y_W-1:0]   y_reg,     y_next;
    logic signed [DEC_W-1:0] dec_reg,   dec_next;
    logic [CENTER_W-1:0]     cx_reg,    cx_next;
    logic [CENTER_W-1:0]     cy_reg,    cy_next;
    logic [COLOR_W-1:0]      color_reg, color_next;
    logic [CNT_W-1:0]        cnt_reg,   cnt_next;

    logic [RADIUS_W-1:0]     r_used;
    logic signed [Y_W-1:0]   r_y;
    logic signed [DEC_W-1:0] r_d;
    logic [X_W-1:0]          x_inc;
    logic signed [Y_W-1:0]   y_dec;
    logic signed [DEC_W-1:0] x_d, xinc_d, ydec_d, y_d;
    logic signed [DEC_W-1:0] dec_diag, dec_axis;

    logic signed [CALC_W-1:0] cx_c, cy_c, x_c, y_c;
    logic signed [CALC_W-1:0] ol_c, or_c, orb_c, ora_c;
    logic signed [CALC_W-1:0] il_c, ir_c, irb_c, ira_c;

    // radius extension and initial decision 3 - 2r
    assign r_used = radius & RADIUS_MASK;
    assign r_y    = $signed({{(Y_W-RADIUS_W){1'b0}}, r_used});
    assign r_d    = $signed({{(DEC_W-RADIUS_W){1'b0}}, r_used});

    // step arithmetic: x first, then the decision update
    assign x_inc    = x_reg + X_W'(1);
    assign y_dec    = y_reg - Y_W'(1);
    assign x_d      = $signed({{(DEC_W-X_W){1'b0}}, x_reg});
    assign xinc_d   = $signed({{(DEC_W-X_W){1'b0}}, x_inc});
    assign ydec_d   = $signed({{(DEC_W-Y_W){y_dec[Y_W-1]}}, y_dec});
    assign y_d      = $signed({{(DEC_W-Y_W){y_reg[Y_W-1]}}, y_reg});
    assign dec_diag = dec_reg + ((xinc_d - ydec_d) <<< 2) + DEC_W'(DEC_STEP_DIAG);
    assign dec_axis = dec_reg + (xinc_d <<< 2) + DEC_W'(DEC_STEP_AXIS);

    // final step once y falls below x or the result cap is reached
    assign status.last = (y_d < x_d) || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    // load / step selection
    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        dec_next   = dec_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        color_next = color_reg;
        cnt_next   = cnt_reg;
        priority if (cmd.load)
        begin
            x_next     = '0;
            y_next     = r_y;
            dec_next   = DEC_W'(DEC_INIT) - (r_d <<< 1);
            cx_next    = center_x;
            cy_next    = center_y;
            color_next = fill_color;
            cnt_next   = '0;
        end
        else if (cmd.step)
        begin
            x_next   = x_inc;
            cnt_next = cnt_reg + CNT_W'(1);
            if (dec_reg > 0)
            begin
                y_next   = y_dec;
                dec_next = dec_diag;
            end
            else
            begin
                dec_next = dec_axis;
            end
        end
    end

    // walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            dec_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            color_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            dec_reg   <= dec_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            color_reg <= color_next;
            cnt_reg   <= cnt_next;
        end
    end

    // span coordinates, wrapped to the result width
    assign cx_c  = $signed({{(CALC_W-CENTER_W){1'b0}}, cx_reg});
    assign cy_c  = $signed({{(CALC_W-CENTER_W){1'b0}}, cy_reg});
    assign x_c   = $signed({{(CALC_W-X_W){1'b0}}, x_reg});
    assign y_c   = $signed({{(CALC_W-Y_W){y_reg[Y_W-1]}}, y_reg});

    assign ol_c  = cx_c - x_c;
    assign or_c  = cx_c + x_c;
    assign orb_c = cy_c + y_c;
    assign ora_c = cy_c - y_c;
    assign il_c  = cx_c - y_c;
    assign ir_c  = cx_c + y_c;
    assign irb_c = cy_c + x_c;
    assign ira_c = cy_c - x_c;

    assign outer_left      = ol_c[COORD_W-1:0];
    assign outer_right     = or_c[COORD_W-1:0];
    assign outer_row_below = orb_c[COORD_W-1:0];
    assign outer_row_above = ora_c[COORD_W-1:0];
    assign inner_left      = il_c[COORD_W-1:0];
    assign inner_right     = ir_c[COORD_W-1:0];
    assign inner_row_below = irb_c[COORD_W-1:0];
    assign inner_row_above = ira_c[COORD_W-1:0];
    assign span_color      = color_reg;

endmodule

`default_nettype wire

// ----- tb/tb_midpoint_circle_span_generator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midpoint_circle_span_generator
// Drives circle requests into the span generator and checks every span beat
// against a local midpoint walk. Small radii, zero radius and coordinates
// that wrap below zero or above 255 are covered first, then random circles.
// Both sides idle at random, except during one long back-to-back stretch, and
// the receiver once holds off for a long stretch so the block stalls its input.
// ----------------------------------------------------------------------------

module tb_midpoint_circle_span_generator;
    import mcsg_pkg::*;

    localparam int IDLE_PCT      = 9;
    localparam int SETTLE_CYCLES = 2 * MAX_RESULTS;
    localparam int STALL_CYCLES  = 300;
    localparam int REPORT_LIMIT  = 40;

    // one span beat as the block should emit it
    typedef struct packed {
        logic signed [COORD_W-1:0] outer_left;
        logic signed [COORD_W-1:0] outer_right;
        logic signed [COORD_W-1:0] outer_row_below;
        logic signed [COORD_W-1:0] outer_row_above;
        logic signed [COORD_W-1:0] inner_left;
        logic signed [COORD_W-1:0] inner_right;
        logic signed [COORD_W-1:0] inner_row_below;
        logic signed [COORD_W-1:0] inner_row_above;
        logic [COLOR_W-1:0]        span_color;
        logic                      last_step;
    } span_beat_t;

    logic clk;
    logic rst_n;

    mcsg_req_if  req();
    mcsg_span_if span();

    span_beat_t pending_spans[$];
    span_beat_t want_beat;
    bit         no_idle;
    bit         hold_off;
    event       hold_start;
    int         mismatch_count = 0;
    int         circles_sent   = 0;
    int         beats_checked  = 0;

    midpoint_circle_span_generator i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .span  (span)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("timeout with %0d span beats still expected", pending_spans.size());
        $display("FAIL");
        $finish;
    end

    // long receiver hold-off, counted in clock cycles
    always
    begin
        @(hold_start);
        hold_off = 1'b1;
        repeat (STALL_CYCLES)
            @(posedge clk);
        hold_off = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [COLOR_W-1:0] want,
                               input logic [COLOR_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s expected %h got %h",
                                      beats_checked, name, want, got));
    endtask

    function automatic logic [COORD_W-1:0] wrap_coord(input int v);
        return COORD_W'(v);
    endfunction

    // spans of one step at offsets (x, y)
    function automatic span_beat_t span_at(input logic [CENTER_W-1:0] cx,
                                           input logic [CENTER_W-1:0] cy,
                                           input int x, input int y,
                                           input logic [COLOR_W-1:0] col);
        span_beat_t b;
        b.outer_left      = wrap_coord(int'(cx) - x);
        b.outer_right     = wrap_coord(int'(cx) + x);
        b.outer_row_below = wrap_coord(int'(cy) + y);
        b.outer_row_above = wrap_coord(int'(cy) - y);
        b.inner_left      = wrap_coord(int'(cx) - y);
        b.inner_right     = wrap_coord(int'(cx) + y);
        b.inner_row_below = wrap_coord(int'(cy) + x);
        b.inner_row_above = wrap_coord(int'(cy) - x);
        b.span_color      = col;
        b.last_step       = 1'b0;
        return b;
    endfunction

    // midpoint walk from the top of the circle to the diagonal
    task automatic plot_circle(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                               input logic [RADIUS_W-1:0] rad,
                               input logic [COLOR_W-1:0] col);
        int         x;
        int         y;
        int         decision;
        int         steps;
        span_beat_t beat;
        x        = 0;
        y        = int'(rad & RADIUS_MASK);
        decision = DEC_INIT - 2 * y;
        beat     = span_at(cx, cy, x, y, col);
        steps    = 1;
        while (y >= x && steps < MAX_RESULTS)
        begin
            pending_spans.push_back(beat);
            x++;
            if (decision > 0)
            begin
                y--;
                decision += 4 * (x - y) + DEC_STEP_DIAG;
            end
            else
            begin
                decision += 4 * x + DEC_STEP_AXIS;
            end
            beat = span_at(cx, cy, x, y, col);
            steps++;
        end
        // final step of the circle
        beat.last_step = 1'b1;
        pending_spans.push_back(beat);
    endtask

    // offer one request beat and wait for it to be taken
    task automatic send_circle(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                               input logic [RADIUS_W-1:0] rad,
                               input logic [COLOR_W-1:0] col);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.center_x   <= cx;
        req.center_y   <= cy;
        req.radius     <= rad;
        req.fill_color <= col;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        plot_circle(cx, cy, rad, col);
        circles_sent++;
    endtask

    task automatic send_random_circle(input int min_radius);
        send_circle(CENTER_W'($urandom), CENTER_W'($urandom),
                    RADIUS_W'($urandom_range(min_radius, (1 << RADIUS_W) - 1)),
                    COLOR_W'($urandom));
    endtask

    // span receiver and checker
    always @(posedge clk)
    begin
        if (rst_n && span.valid && span.ready)
        begin
            if (pending_spans.size() == 0)
            begin
                report_mismatch($sformatf("span beat with none expected, outer_left %h",
                                          span.outer_left));
            end
            else
            begin
                want_beat = pending_spans.pop_front();
                check_field("outer_left", COLOR_W'(want_beat.outer_left),
                            COLOR_W'(span.outer_left));
                check_field("outer_right", COLOR_W'(want_beat.outer_right),
                            COLOR_W'(span.outer_right));
                check_field("outer_row_below", COLOR_W'(want_beat.outer_row_below),
                            COLOR_W'(span.outer_row_below));
                check_field("outer_row_above", COLOR_W'(want_beat.outer_row_above),
                            COLOR_W'(span.outer_row_above));
                check_field("inner_left", COLOR_W'(want_beat.inner_left),
                            COLOR_W'(span.inner_left));
                check_field("inner_right", COLOR_W'(want_beat.inner_right),
                            COLOR_W'(span.inner_right));
                check_field("inner_row_below", COLOR_W'(want_beat.inner_row_below),
                            COLOR_W'(span.inner_row_below));
                check_field("inner_row_above", COLOR_W'(want_beat.inner_row_above),
                            COLOR_W'(span.inner_row_above));
                check_field("span_color", want_beat.span_color, span.span_color);
                check_field("last_step", COLOR_W'(want_beat.last_step),
                            COLOR_W'(span.last_step));
            end
            beats_checked++;
        end
        // ready for the next cycle: long hold-off first, then random stalls
        if (hold_off)
        begin
            span.ready <= 1'b0;
        end
        else
        begin
            span.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // zero radius walks one step past the center, tiny radii end quickly
    task automatic test_small_radii();
        send_circle(8'd128, 8'd128, 6'd0, 16'h1234);
        send_circle(8'd100, 8'd60, 6'd1, 16'h0F0F);
        send_circle(8'd20, 8'd200, 6'd2, 16'hF0F0);
        send_circle(8'd7, 8'd9, 6'd3, 16'h8001);
        send_circle(8'd200, 8'd30, 6'd5, 16'h7FFE);
    endtask

    // centers at the edges so columns and rows leave 0..255
    task automatic test_coordinate_wrap();
        send_circle(8'd0, 8'd0, 6'd63, 16'h0000);
        send_circle(8'd255, 8'd255, 6'd63, 16'hFFFF);
        send_circle(8'd0, 8'd255, 6'd63, 16'h00FF);
        send_circle(8'd255, 8'd0, 6'd63, 16'hFF00);
        send_circle(8'd0, 8'd0, 6'd0, 16'hC3C3);
        send_circle(8'd255, 8'd255, 6'd0, 16'h3C3C);
    endtask

    // alternating color and radius bit patterns
    task automatic test_color_passthrough();
        send_circle(8'hAA, 8'h55, 6'd42, 16'hAAAA);
        send_circle(8'h55, 8'hAA, 6'd21, 16'h5555);
        send_circle(8'd64, 8'd192, 6'd32, 16'hFFFF);
        send_circle(8'd192, 8'd64, 6'd16, 16'h0001);
    endtask

    // long stretch with no idling on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (20)
            send_random_circle(0);
        no_idle = 1'b0;
    endtask

    // receiver holds off while further requests are offered
    task automatic test_output_stall();
        -> hold_start;
        repeat (5)
            send_random_circle(20);
    endtask

    task automatic test_random_circles();
        repeat (225)
            send_random_circle(0);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        no_idle        = 1'b0;
        req.valid      = 1'b0;
        req.center_x   = '0;
        req.center_y   = '0;
        req.radius     = '0;
        req.fill_color = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_radii();
        test_coordinate_wrap();
        test_color_passthrough();
        test_back_to_back();
        test_output_stall();
        test_random_circles();
        req.valid <= 1'b0;

        // drain, then give stray beats a chance to show up
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("%0d circles drawn, %0d span beats compared, %0d mismatches",
                 circles_sent, beats_checked, mismatch_count);
        $display("covered zero and full radius, edge centers, stalls on both sides");
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
